[design/zre_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and controller/datapath interface types for the zero-run encoder.
// Depends on nothing; used by zre_ctrl, zre_dpath and zero_run_encoder.
package zre_pkg;

    localparam int PART_MAX  = 8;    // bytes per part
    localparam int LIT_DEPTH = 16;   // literal bytes per group (two data parts)

    localparam int LIT_AW = $clog2(LIT_DEPTH);
    localparam int LIT_CW = $clog2(LIT_DEPTH + 1);
    localparam int PART_CW = $clog2(PART_MAX + 1);

    localparam logic [7:0] ZERO_BYTE = 8'h00;

    // which opcode layout the datapath builds
    typedef enum logic [0:0] {
        OPK_PAIR  = 1'b0,   // first code + code of the open second part
        OPK_FLUSH = 1'b1    // stream end: missing second part codes as 0
    } opkind_t;

    typedef struct packed {
        logic    take;        // latch input beat
        logic    apply_in;    // fold input port byte into the part state
        logic    apply;       // fold latched byte into the part state
        logic    close_first; // full first part: close it
        logic    op_load;     // load group opcode into output register
        opkind_t op_kind;
        logic    grp_last;    // group being sent ends the results of this beat
        logic    lit_load;    // load next literal into output register
        logic    grp_clear;   // group fully sent: back to empty state
    } zre_cmd_t;

    typedef struct packed {
        logic need_emit;    // input byte closes the second part of the open group
        logic full_second;
        logic full_first;
        logic end_open;     // stream end with a group still open
        logic end_flag;     // latched stream_end
        logic lit_empty;
        logic lit_final;    // next literal is the last of the group
        logic out_free;
    } zre_stat_t;

endpackage

[design/zre_dpath.sv]
`timescale 1ns / 1ps
// Datapath of the zero-run encoder: part/group state, literal store, output register.
// Depends on zre_pkg; driven by zre_ctrl through zre_cmd_t.
module zre_dpath
(
    input  logic                clk,
    input  logic                rst_n,
    input  zre_pkg::zre_cmd_t   cmd,
    output zre_pkg::zre_stat_t  stat,
    input  logic [7:0]          data_byte,
    input  logic                stream_end,
    output logic                enc_valid,
    input  logic                enc_stall,
    output logic [7:0]          out_byte,
    output logic                is_opcode,
    output logic                run_last,
    output logic                stream_last
);

    logic [7:0]                  byte_reg;
    logic                        end_reg;
    logic                        group_open_reg, group_open_next;
    logic                        in_second_reg, in_second_next;
    logic                        piz_reg, piz_next;
    logic [zre_pkg::PART_CW-1:0] count_reg, count_next;
    logic [3:0]                  first_code_reg, first_code_next;
    logic [zre_pkg::LIT_CW-1:0]  lit_count_reg, lit_count_next;
    logic [zre_pkg::LIT_AW-1:0]  idx_reg, idx_next;
    logic [7:0]                  lit_mem [zre_pkg::LIT_DEPTH];

    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  out_byte_reg;
    logic                        is_op_reg, run_last_reg, stream_last_reg;

    logic [7:0]                  apply_byte;
    logic                        do_apply;
    logic                        z;
    logic [zre_pkg::LIT_CW-1:0]  lit_base;
    logic                        mem_we;
    logic [zre_pkg::LIT_AW-1:0]  mem_wa;
    logic [3:0]                  cur_nib;
    logic [7:0]                  opcode;
    logic                        beat_last;

    // zero part codes count-1, data part codes (8 - count) mod 8
    function automatic logic [3:0] nib(input logic is_zero,
                                       input logic [zre_pkg::PART_CW-1:0] cnt);
        logic [2:0] c;
        c = is_zero ? 3'(cnt - 1'b1) : 3'(-cnt);
        return {is_zero, c};
    endfunction

    assign apply_byte = cmd.apply_in ? data_byte : byte_reg;
    assign do_apply   = cmd.apply_in | cmd.apply;
    assign z          = (apply_byte == zre_pkg::ZERO_BYTE);
    assign cur_nib    = nib(piz_reg, count_reg);

    always_comb
    begin
        group_open_next = group_open_reg;
        in_second_next  = in_second_reg;
        piz_next        = piz_reg;
        count_next      = count_reg;
        first_code_next = first_code_reg;
        lit_count_next  = lit_count_reg;
        lit_base        = lit_count_reg;
        mem_we          = 1'b0;
        mem_wa          = lit_count_reg[zre_pkg::LIT_AW-1:0];
        if (cmd.grp_clear)
        begin
            group_open_next = 1'b0;
            in_second_next  = 1'b0;
            piz_next        = 1'b0;
            count_next      = '0;
            first_code_next = '0;
            lit_count_next  = '0;
        end
        else if (cmd.close_first)
        begin
            first_code_next = cur_nib;
            in_second_next  = 1'b1;
            count_next      = '0;
            piz_next        = 1'b0;
        end
        else if (do_apply)
        begin
            if (!group_open_reg)
            begin
                group_open_next = 1'b1;
                in_second_next  = 1'b0;
                first_code_next = '0;
                piz_next        = z;
                count_next      = zre_pkg::PART_CW'(1);
                lit_base        = '0;
            end
            else if (!in_second_reg)
            begin
                if (z == piz_reg && count_reg < zre_pkg::PART_CW'(zre_pkg::PART_MAX))
                begin
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    first_code_next = cur_nib;
                    in_second_next  = 1'b1;
                    piz_next        = z;
                    count_next      = zre_pkg::PART_CW'(1);
                end
            end
            else if (count_reg == '0)
            begin
                piz_next   = z;
                count_next = zre_pkg::PART_CW'(1);
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
            lit_count_next = lit_base;
            mem_wa         = lit_base[zre_pkg::LIT_AW-1:0];
            if (!z && lit_base < zre_pkg::LIT_CW'(zre_pkg::LIT_DEPTH))
            begin
                mem_we         = 1'b1;
                lit_count_next = lit_base + 1'b1;
            end
        end
    end

    always_comb
    begin
        unique case (cmd.op_kind)
            zre_pkg::OPK_PAIR:
                opcode = {cur_nib, first_code_reg};
            zre_pkg::OPK_FLUSH:
            begin
                if (!in_second_reg)
                    opcode = {4'h0, cur_nib};
                else if (count_reg == '0)
                    opcode = {4'h0, first_code_reg};
                else
                    opcode = {cur_nib, first_code_reg};
            end
            default:
                opcode = {cur_nib, first_code_reg};
        endcase
    end

    assign beat_last = cmd.grp_last & (cmd.op_load ? stat.lit_empty : stat.lit_final);

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.op_load)
            idx_next = '0;
        else if (cmd.lit_load)
            idx_next = idx_reg + 1'b1;
    end

    assign out_valid_next = (cmd.op_load | cmd.lit_load) | (out_valid_reg & enc_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_open_reg <= 1'b0;
            in_second_reg  <= 1'b0;
            piz_reg        <= 1'b0;
            count_reg      <= '0;
            first_code_reg <= '0;
            lit_count_reg  <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            group_open_reg <= group_open_next;
            in_second_reg  <= in_second_next;
            piz_reg        <= piz_next;
            count_reg      <= count_next;
            first_code_reg <= first_code_next;
            lit_count_reg  <= lit_count_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            byte_reg <= data_byte;
            end_reg  <= stream_end;
        end
        if (mem_we)
            lit_mem[mem_wa] <= apply_byte;
        if (cmd.op_load)
        begin
            out_byte_reg    <= opcode;
            is_op_reg       <= 1'b1;
            run_last_reg    <= beat_last;
            stream_last_reg <= beat_last & end_reg;
        end
        else if (cmd.lit_load)
        begin
            out_byte_reg    <= lit_mem[idx_reg];
            is_op_reg       <= 1'b0;
            run_last_reg    <= beat_last;
            stream_last_reg <= beat_last & end_reg;
        end
    end

    always_comb
    begin
        stat.need_emit   = group_open_reg & in_second_reg & (count_reg != '0) &
                           (((data_byte == zre_pkg::ZERO_BYTE) != piz_reg) |
                            (count_reg >= zre_pkg::PART_CW'(zre_pkg::PART_MAX)));
        stat.full_second = group_open_reg & in_second_reg &
                           (count_reg >= zre_pkg::PART_CW'(zre_pkg::PART_MAX));
        stat.full_first  = group_open_reg & ~in_second_reg &
                           (count_reg >= zre_pkg::PART_CW'(zre_pkg::PART_MAX));
        stat.end_open    = end_reg & group_open_reg;
        stat.end_flag    = end_reg;
        stat.lit_empty   = (lit_count_reg == '0);
        stat.lit_final   = ((zre_pkg::LIT_CW'(idx_reg) + 1'b1) == lit_count_reg);
        stat.out_free    = ~out_valid_reg | ~enc_stall;
    end

    assign enc_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign is_opcode   = is_op_reg;
    assign run_last    = run_last_reg;
    assign stream_last = stream_last_reg;

    a_lit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lit_count_reg <= zre_pkg::LIT_CW'(zre_pkg::LIT_DEPTH))
        else $error("literal count beyond store depth");

    a_part_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= zre_pkg::PART_CW'(zre_pkg::PART_MAX))
        else $error("part count beyond part size");

    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !group_open_reg |-> (lit_count_reg == '0 && count_reg == '0 && !in_second_reg))
        else $error("closed group holds state");

    a_stream_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && stream_last_reg) |-> run_last_reg)
        else $error("stream_last without run_last");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.grp_clear && !cmd.op_load) |-> stat.lit_final)
        else $error("group cleared before final literal");

endmodule

[design/zre_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer of the zero-run encoder: accepts beats and steps group emission.
// Depends on zre_pkg; drives zre_dpath through zre_cmd_t.
module zre_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                raw_valid,
    output logic                raw_stall,
    input  zre_pkg::zre_stat_t  stat,
    output zre_pkg::zre_cmd_t   cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_OPC   = 5'b00100,
        ST_LIT   = 5'b01000,
        ST_APPLY = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic             chg_reg, chg_next;     // emission caused by a class change
    zre_pkg::opkind_t kind_reg, kind_next;

    always_comb
    begin
        cmd        = '0;
        cmd.op_kind = kind_reg;
        cmd.grp_last = chg_reg ? ~stat.end_flag : 1'b1;
        state_next = state_reg;
        chg_next   = chg_reg;
        kind_next  = kind_reg;
        raw_stall  = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (raw_valid)
                begin
                    cmd.take = 1'b1;
                    if (stat.need_emit)
                    begin
                        chg_next   = 1'b1;
                        kind_next  = zre_pkg::OPK_PAIR;
                        state_next = ST_OPC;
                    end
                    else
                    begin
                        cmd.apply_in = 1'b1;
                        state_next   = ST_CHECK;
                    end
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                chg_next   = 1'b0;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                priority if (stat.full_second)
                begin
                    kind_next  = zre_pkg::OPK_PAIR;
                    state_next = ST_OPC;
                end
                else if (stat.end_open)
                begin
                    kind_next  = zre_pkg::OPK_FLUSH;
                    state_next = ST_OPC;
                end
                else if (stat.full_first)
                begin
                    cmd.close_first = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OPC:
            begin
                if (stat.out_free)
                begin
                    cmd.op_load = 1'b1;
                    if (stat.lit_empty)
                    begin
                        cmd.grp_clear = 1'b1;
                        state_next    = chg_reg ? ST_APPLY : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_LIT;
                    end
                end
            end
            ST_LIT:
            begin
                if (stat.out_free)
                begin
                    cmd.lit_load = 1'b1;
                    if (stat.lit_final)
                    begin
                        cmd.grp_clear = 1'b1;
                        state_next    = chg_reg ? ST_APPLY : ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chg_reg   <= 1'b0;
            kind_reg  <= zre_pkg::OPK_PAIR;
        end
        else
        begin
            state_reg <= state_next;
            chg_reg   <= chg_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

[design/zero_run_encoder.sv]
`timescale 1ns / 1ps
// Zero-run encoder top level: a beat that sends no group passes through accept and part check.
// A beat that sends a group then sends one output byte per cycle while enc_stall is low (opcode
// plus its literals, up to 17 bytes per beat, also when a class change and stream end both emit).
// A class change folds the byte into the new group (ST_APPLY) after the old group is sent.
// Output bytes come from one output register, first loaded in ST_OPC, reached from accept or via the part check.
// Reset (rst_n, async, active low) empties the open group and the output register.
module zero_run_encoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       raw_valid,
    output logic       raw_stall,
    input  logic [7:0] data_byte,
    input  logic       stream_end,
    output logic       enc_valid,
    input  logic       enc_stall,
    output logic [7:0] out_byte,
    output logic       is_opcode,
    output logic       run_last,
    output logic       stream_last
);

    zre_pkg::zre_cmd_t  cmd;
    zre_pkg::zre_stat_t stat;

    zre_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw_valid),
        .raw_stall (raw_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    zre_dpath u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .data_byte   (data_byte),
        .stream_end  (stream_end),
        .enc_valid   (enc_valid),
        .enc_stall   (enc_stall),
        .out_byte    (out_byte),
        .is_opcode   (is_opcode),
        .run_last    (run_last),
        .stream_last (stream_last)
    );

endmodule

[sim/tb_zero_run_encoder.sv]
`timescale 1ns / 1ps
// Self-checking testbench for zero_run_encoder: drives raw byte streams with random
// idling on both sides and checks every compressed beat against a behavioral encoder.
// Depends on zre_pkg and zero_run_encoder.
module tb_zero_run_encoder;

    typedef struct {
        logic [7:0] value;
        logic       opcode;
        logic       beat_last;
        logic       strm_last;
    } enc_out_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       raw_valid = 1'b0;
    logic       raw_stall;
    logic [7:0] data_byte = 8'h00;
    logic       stream_end = 1'b0;
    logic       enc_valid;
    logic       enc_stall = 1'b0;
    logic [7:0] out_byte;
    logic       is_opcode;
    logic       run_last;
    logic       stream_last;

    bit       steady;   // no idling on either side while set
    int       errors;
    enc_out_t compressed_q[$];
    enc_out_t beat_res[$];
    enc_out_t want;

    // encoder state
    bit       grp_open;
    bit       in_second;
    bit       part_zero;
    bit [3:0] part_cnt;
    bit [3:0] head_code;
    bit [7:0] lit_mem[zre_pkg::LIT_DEPTH];
    bit [4:0] lit_cnt;

    zero_run_encoder dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .raw_valid   (raw_valid),
        .raw_stall   (raw_stall),
        .data_byte   (data_byte),
        .stream_end  (stream_end),
        .enc_valid   (enc_valid),
        .enc_stall   (enc_stall),
        .out_byte    (out_byte),
        .is_opcode   (is_opcode),
        .run_last    (run_last),
        .stream_last (stream_last)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ---------------- encoder prediction ----------------

    // zero part: count-1, data part: (8-count) mod 8; bit 3 marks a zero part
    function automatic bit [3:0] part_code(input bit zero, input bit [3:0] cnt);
        bit [2:0] c;
        c = zero ? 3'(cnt - 1) : 3'(zre_pkg::PART_MAX - cnt);
        return {zero, c};
    endfunction

    task automatic clear_encoder();
        grp_open  = 1'b0;
        in_second = 1'b0;
        part_zero = 1'b0;
        part_cnt  = '0;
        head_code = '0;
        lit_cnt   = '0;
    endtask

    task automatic push_literal(input bit [7:0] b);
        if (lit_cnt < zre_pkg::LIT_DEPTH)
        begin
            lit_mem[lit_cnt[3:0]] = b;
            lit_cnt++;
        end
    endtask

    task automatic start_part(input bit z, input bit [7:0] b);
        part_zero = z;
        part_cnt  = 4'd1;
        if (!z)
            push_literal(b);
    endtask

    task automatic grow_part(input bit z, input bit [7:0] b);
        part_cnt++;
        if (!z)
            push_literal(b);
    endtask

    task automatic open_group(input bit z, input bit [7:0] b);
        grp_open  = 1'b1;
        in_second = 1'b0;
        lit_cnt   = '0;
        head_code = '0;
        start_part(z, b);
    endtask

    task automatic close_first();
        head_code = part_code(part_zero, part_cnt);
        in_second = 1'b1;
        part_cnt  = '0;
        part_zero = 1'b0;
    endtask

    task automatic emit_group(input bit [3:0] lo, input bit [3:0] hi);
        enc_out_t r;
        r = '{{hi, lo}, 1'b1, 1'b0, 1'b0};
        beat_res.insert(beat_res.size(), r);
        for (int i = 0; i < lit_cnt; i++)
        begin
            r = '{lit_mem[i], 1'b0, 1'b0, 1'b0};
            beat_res.insert(beat_res.size(), r);
        end
        clear_encoder();
    endtask

    task automatic predict_beat(input bit [7:0] b, input bit e);
        bit z;
        z = (b == zre_pkg::ZERO_BYTE);
        beat_res.delete();
        if (!grp_open)
            open_group(z, b);
        else if (!in_second)
        begin
            if (z == part_zero && part_cnt < zre_pkg::PART_MAX)
                grow_part(z, b);
            else
            begin
                close_first();
                start_part(z, b);
            end
        end
        else if (part_cnt == 0)
            start_part(z, b);
        else if (z == part_zero && part_cnt < zre_pkg::PART_MAX)
            grow_part(z, b);
        else
        begin
            // class change in the second part closes the group
            emit_group(head_code, part_code(part_zero, part_cnt));
            open_group(z, b);
        end

        if (grp_open && part_cnt >= zre_pkg::PART_MAX)
        begin
            if (!in_second)
                close_first();
            else
                emit_group(head_code, part_code(part_zero, part_cnt));
        end

        if (e)
        begin
            if (grp_open)
            begin
                if (!in_second)
                    emit_group(part_code(part_zero, part_cnt), 4'd0);
                else if (part_cnt == 0)
                    emit_group(head_code, 4'd0);
                else
                    emit_group(head_code, part_code(part_zero, part_cnt));
            end
            clear_encoder();
        end

        if (beat_res.size() > 0)
        begin
            beat_res[$].beat_last = 1'b1;
            beat_res[$].strm_last = e;
        end
        foreach (beat_res[i])
            compressed_q.insert(compressed_q.size(), beat_res[i]);
    endtask

    // ---------------- driving and checking ----------------

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_byte(input bit [7:0] b, input bit e);
        if (!steady)
            while ($urandom_range(99) < 34)
            begin
                raw_valid = 1'b0;
                @(negedge clk);
            end
        raw_valid  = 1'b1;
        data_byte  = b;
        stream_end = e;
        @(posedge clk);
        while (raw_stall)
            @(posedge clk);
        predict_beat(b, e);
        @(negedge clk);
    endtask

    always @(negedge clk)
        enc_stall <= !steady && ($urandom_range(99) < 34);

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected 0x%02h, got 0x%02h", name, exp_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && enc_valid && !enc_stall)
        begin
            if (compressed_q.size() == 0)
            begin
                $error("out_byte: expected no beat, got 0x%02h", out_byte);
                errors++;
            end
            else
            begin
                want = compressed_q.pop_front();
                check_field("out_byte", want.value, out_byte);
                check_field("is_opcode", want.opcode, is_opcode);
                check_field("run_last", want.beat_last, run_last);
                check_field("stream_last", want.strm_last, stream_last);
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_single_byte_streams();
        send_byte(zre_pkg::ZERO_BYTE, 1'b1);
        send_byte(8'hFF, 1'b1);
    endtask

    // full first data part ends the stream before the second part starts
    task automatic test_full_first_flush();
        for (int i = 0; i < zre_pkg::PART_MAX; i++)
            send_byte(8'(1 << i), i == zre_pkg::PART_MAX - 1);
    endtask

    // full second part emits the group on the filling byte, which also ends the stream
    task automatic test_full_second();
        send_byte(zre_pkg::ZERO_BYTE, 1'b0);
        for (int i = 0; i < zre_pkg::PART_MAX; i++)
            send_byte(~8'(1 << i), i == zre_pkg::PART_MAX - 1);
    endtask

    task automatic test_class_change();
        send_byte(zre_pkg::ZERO_BYTE, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(zre_pkg::ZERO_BYTE, 1'b0);
        send_byte(8'hA5, 1'b1);
    endtask

    task automatic test_random_streams(input int n_items);
        int sent;
        int runs;
        int len;
        bit zero_run;
        sent = 0;
        while (sent < n_items)
        begin
            runs = $urandom_range(1, 6);
            zero_run = $urandom_range(1);
            for (int r = 0; r < runs; r++)
            begin
                len = $urandom_range(1, 9);
                for (int k = 0; k < len; k++)
                begin
                    steady = (sent < 60);
                    send_byte(zero_run ? zre_pkg::ZERO_BYTE : 8'($urandom_range(1, 255)),
                              r == runs - 1 && k == len - 1);
                    sent++;
                end
                if ($urandom_range(99) < 80)
                    zero_run = !zero_run;
            end
        end
        steady = 1'b0;
    endtask

    // sender holds off mid-stream until every pending output beat has drained
    task automatic test_drain_pause();
        for (int i = 0; i < 20; i++)
            send_byte(($urandom_range(99) < 45) ? zre_pkg::ZERO_BYTE
                                                : 8'($urandom_range(1, 255)),
                      1'b0);
        raw_valid = 1'b0;
        wait (compressed_q.size() == 0);
        @(negedge clk);
        for (int i = 0; i < 5; i++)
            send_byte(8'($urandom_range(0, 255)), i == 4);
    endtask

    task automatic test_noise(input int n_items);
        for (int i = 0; i < n_items; i++)
            send_byte(($urandom_range(99) < 40) ? zre_pkg::ZERO_BYTE
                                                : 8'($urandom_range(0, 255)),
                      $urandom_range(99) < 8);
    endtask

    initial
    begin
        clear_encoder();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_single_byte_streams();
        test_full_first_flush();
        test_full_second();
        test_class_change();
        test_random_streams(280);
        test_drain_pause();
        test_noise(45);

        raw_valid = 1'b0;
        wait (compressed_q.size() == 0);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
